// ===== rtl/spr_pkg.sv =====
// Shared types, constants and register codes for the servo pulse ramp controller.
package spr_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam int WIDTH_W     = 16;
    localparam int ANGLE_W     = 8;
    localparam int CPU_W       = 7;
    localparam int SHIFT_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Fixed shift of the compare word: widths are in 1/16 us
    localparam logic [3:0] FRAC_SHIFT = 4'd4;

    localparam logic signed [ANGLE_W-1:0] ANGLE_HI = 8'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LO = -8'sd90;
    localparam int ANGLE_SPAN = 180;

    // Reciprocal of the angle span for the angle to width map
    localparam int RECIP_SHIFT = 31;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / ANGLE_SPAN;
    localparam logic [23:0] RECIP_SPAN = 24'(RECIP_FULL);

    localparam logic [CPU_W-1:0]   RST_CLOCKS_PER_US  = 7'd4;
    localparam logic [SHIFT_W-1:0] RST_PRESCALE_SHIFT = 3'd4;
    localparam logic [WIDTH_W-1:0] RST_NEG_END_WIDTH  = 16'd8000;
    localparam logic [WIDTH_W-1:0] RST_POS_END_WIDTH  = 16'd38400;
    localparam logic [WIDTH_W-1:0] RST_RAMP_STRIDE    = 16'd16;

    typedef enum logic [2:0] {
        OP_SET_WIDTH  = 3'd0,
        OP_RAMP_WIDTH = 3'd1,
        OP_SET_ANGLE  = 3'd2,
        OP_RAMP_ANGLE = 3'd3,
        OP_TICK       = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLOCKS_PER_US  = 3'd0,
        REG_PRESCALE_SHIFT = 3'd1,
        REG_NEG_END_WIDTH  = 3'd2,
        REG_POS_END_WIDTH  = 3'd3,
        REG_RAMP_STRIDE    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CPU_W-1:0]   clocks_per_us;
        logic [SHIFT_W-1:0] prescale_shift;
        logic [WIDTH_W-1:0] neg_end_width;
        logic [WIDTH_W-1:0] pos_end_width;
        logic [WIDTH_W-1:0] ramp_stride;
    } cfg_t;

    typedef struct packed {
        op_t                        op;
        logic                       ch;
        logic signed [ANGLE_W-1:0]  ang;
        logic [ANGLE_W-1:0]         ang_ofs;
        logic [WIDTH_W-1:0]         wval;
    } cmd_t;

endpackage

// ===== rtl/spr_front.sv =====
// Front end: takes input items, clamps the angle, saturates the channel and queues a command.
module spr_front
    import spr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 opcode,
    input  logic                       channel,
    input  logic [WIDTH_W-1:0]         width_value,
    input  logic signed [ANGLE_W-1:0]  angle,
    input  logic                       q_full,
    output logic                       q_push,
    output cmd_t                       q_cmd
);

    logic signed [ANGLE_W-1:0] ang_clamped;

    always_comb
    begin
        if (angle < ANGLE_LO)
        begin
            ang_clamped = ANGLE_LO;
        end
        else if (angle > ANGLE_HI)
        begin
            ang_clamped = ANGLE_HI;
        end
        else
        begin
            ang_clamped = angle;
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.op      = op_t'(opcode);
        // a one-channel build folds channel 1 onto channel 0
        q_cmd.ch      = (CHANNELS > 1) ? channel : 1'b0;
        q_cmd.ang     = ang_clamped;
        q_cmd.ang_ofs = ang_clamped + ANGLE_HI;
        q_cmd.wval    = width_value;
    end

endmodule

// ===== rtl/spr_queue.sv =====
// Short command queue between front end and back end.
module spr_queue
    import spr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/spr_back.sv =====
// Back end: per-channel width state, angle map, ramp step, compare word and result register.
module spr_back
    import spr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       q_valid,
    input  cmd_t                       q_cmd,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_channel,
    output logic [7:0]                 compare_high,
    output logic [1:0]                 compare_low,
    output logic [WIDTH_W-1:0]         current_width,
    output logic signed [ANGLE_W-1:0]  current_angle,
    output logic                       at_target
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SPAN_W = WIDTH_W + 1;
    localparam int PROD_W = SPAN_W + ANGLE_W;
    localparam int RCP_W  = PROD_W + 24;
    localparam int CMP_W  = WIDTH_W + CPU_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_RECIP = 7'b0001000,
        ST_FIX   = 7'b0010000,
        ST_CMP   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    cmd_t                      cmd_reg;
    logic [WIDTH_W-1:0]        width_now_reg  [CHANNELS];
    logic [WIDTH_W-1:0]        width_goal_reg [CHANNELS];
    logic signed [ANGLE_W-1:0] angle_last_reg [CHANNELS];
    logic [PROD_W-1:0]         prod_reg;
    logic                      span_neg_reg;
    logic [RCP_W-1:0]          recip_reg;
    logic [CMP_W-1:0]          cmp_prod_reg;
    logic                      out_valid_reg;
    logic                      out_channel_reg;
    logic [7:0]                compare_high_reg;
    logic [1:0]                compare_low_reg;
    logic [WIDTH_W-1:0]        current_width_reg;
    logic signed [ANGLE_W-1:0] current_angle_reg;
    logic                      at_target_reg;

    logic [CH_W-1:0]    idx;
    logic [WIDTH_W-1:0] now_w;
    logic [WIDTH_W-1:0] goal_w;
    logic [SPAN_W-1:0]  up_sum;
    logic [WIDTH_W-1:0] down_gap;
    logic [WIDTH_W-1:0] ramp_w;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  span_mag;
    logic [SPAN_W-1:0]  q_est;
    logic [PROD_W-1:0]  q_times_span;
    logic [PROD_W-1:0]  rem;
    logic [SPAN_W-1:0]  q_fix;
    logic [WIDTH_W-1:0] map_w;
    logic [3:0]         cmp_shift;
    logic [CMP_W-1:0]   cmp_word;
    logic               wr_now;
    logic               wr_goal;
    logic               wr_angle;
    logic [WIDTH_W-1:0] now_next;
    logic [WIDTH_W-1:0] goal_next;
    logic               out_load;

    assign idx    = CH_W'(cmd_reg.ch);
    assign now_w  = width_now_reg[idx];
    assign goal_w = width_goal_reg[idx];

    // one tick of slew toward the goal, never past it
    always_comb
    begin
        up_sum   = {1'b0, now_w} + {1'b0, cfg.ramp_stride};
        down_gap = now_w - goal_w;
        if (now_w < goal_w)
        begin
            ramp_w = (up_sum > {1'b0, goal_w}) ? goal_w : up_sum[WIDTH_W-1:0];
        end
        else if (now_w > goal_w)
        begin
            ramp_w = (down_gap > cfg.ramp_stride) ? now_w - cfg.ramp_stride : goal_w;
        end
        else
        begin
            ramp_w = now_w;
        end
    end

    // angle map: neg + trunc(span * (angle + 90) / 180), on the span magnitude
    always_comb
    begin
        span         = {1'b0, cfg.pos_end_width} - {1'b0, cfg.neg_end_width};
        span_mag     = span[SPAN_W-1] ? (~span + 1'b1) : span;
        q_est        = recip_reg[RECIP_SHIFT +: SPAN_W];
        q_times_span = PROD_W'(q_est) * PROD_W'(ANGLE_SPAN);
        rem          = prod_reg - q_times_span;
        q_fix        = (rem >= PROD_W'(ANGLE_SPAN)) ? q_est + 1'b1 : q_est;
        map_w        = span_neg_reg ? cfg.neg_end_width - q_fix[WIDTH_W-1:0]
                                    : cfg.neg_end_width + q_fix[WIDTH_W-1:0];
    end

    assign cmp_shift = FRAC_SHIFT + {1'b0, cfg.prescale_shift};
    assign cmp_word  = cmp_prod_reg >> cmp_shift;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        wr_now     = 1'b0;
        wr_goal    = 1'b0;
        wr_angle   = 1'b0;
        now_next   = cmd_reg.wval;
        goal_next  = cmd_reg.wval;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_CMP;
                case (cmd_reg.op)
                    OP_SET_WIDTH:
                    begin
                        wr_now  = 1'b1;
                        wr_goal = 1'b1;
                    end
                    OP_RAMP_WIDTH:
                    begin
                        wr_goal = 1'b1;
                    end
                    OP_SET_ANGLE, OP_RAMP_ANGLE:
                    begin
                        state_next = ST_MUL;
                    end
                    OP_TICK:
                    begin
                        wr_now   = 1'b1;
                        now_next = ramp_w;
                    end
                    default:
                    begin
                        // unused opcode: report only
                    end
                endcase
            end
            ST_MUL:
            begin
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                state_next = ST_CMP;
                wr_angle   = 1'b1;
                wr_goal    = 1'b1;
                goal_next  = map_w;
                now_next   = map_w;
                wr_now     = (cmd_reg.op == OP_SET_ANGLE);
            end
            ST_CMP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                width_now_reg[i]  <= '0;
                width_goal_reg[i] <= '0;
                angle_last_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr_now)
            begin
                width_now_reg[idx] <= now_next;
            end
            if (wr_goal)
            begin
                width_goal_reg[idx] <= goal_next;
            end
            if (wr_angle)
            begin
                angle_last_reg[idx] <= cmd_reg.ang;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg     <= PROD_W'(span_mag) * PROD_W'(cmd_reg.ang_ofs);
            span_neg_reg <= span[SPAN_W-1];
        end
        if (state_reg == ST_RECIP)
        begin
            recip_reg <= RCP_W'(prod_reg) * RCP_W'(RECIP_SPAN);
        end
        if (state_reg == ST_CMP)
        begin
            cmp_prod_reg <= CMP_W'(now_w) * CMP_W'(cfg.clocks_per_us);
        end
        if (out_load)
        begin
            out_channel_reg   <= cmd_reg.ch;
            compare_high_reg  <= cmp_word[9:2];
            compare_low_reg   <= cmp_word[1:0];
            current_width_reg <= now_w;
            current_angle_reg <= angle_last_reg[idx];
            at_target_reg     <= (now_w == goal_w);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign compare_high  = compare_high_reg;
    assign compare_low   = compare_low_reg;
    assign current_width = current_width_reg;
    assign current_angle = current_angle_reg;
    assign at_target     = at_target_reg;

endmodule

// ===== rtl/servo_pulse_ramp_controller_top.sv =====
// Top level: configuration registers and the front end, queue and back end.
// out_valid rises once an item has passed the queue and the back-end states IDLE, EXEC,
// CMP and OUT (width, tick and unused opcodes; angle commands add MUL, RECIP and FIX),
// and a stalled result holds the next one back. The back end takes no new item until
// the last result is loaded; a two-entry queue takes items while a result waits to be taken.
// Reset (rst_n low, asynchronous) zeroes widths, goals and angles and restores the registers.
module servo_pulse_ramp_controller_top
    import spr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 opcode,
    input  logic                       channel,
    input  logic [WIDTH_W-1:0]         width_value,
    input  logic signed [ANGLE_W-1:0]  angle,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_channel,
    output logic [7:0]                 compare_high,
    output logic [1:0]                 compare_low,
    output logic [WIDTH_W-1:0]         current_width,
    output logic signed [ANGLE_W-1:0]  current_angle,
    output logic                       at_target
);

    cfg_t cfg_reg;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clocks_per_us  <= RST_CLOCKS_PER_US;
            cfg_reg.prescale_shift <= RST_PRESCALE_SHIFT;
            cfg_reg.neg_end_width  <= RST_NEG_END_WIDTH;
            cfg_reg.pos_end_width  <= RST_POS_END_WIDTH;
            cfg_reg.ramp_stride    <= RST_RAMP_STRIDE;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CLOCKS_PER_US:  cfg_reg.clocks_per_us  <= cfg_data[CPU_W-1:0];
                REG_PRESCALE_SHIFT: cfg_reg.prescale_shift <= cfg_data[SHIFT_W-1:0];
                REG_NEG_END_WIDTH:  cfg_reg.neg_end_width  <= cfg_data;
                REG_POS_END_WIDTH:  cfg_reg.pos_end_width  <= cfg_data;
                REG_RAMP_STRIDE:    cfg_reg.ramp_stride    <= cfg_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    spr_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .channel     (channel),
        .width_value (width_value),
        .angle       (angle),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    spr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    spr_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_channel   (out_channel),
        .compare_high  (compare_high),
        .compare_low   (compare_low),
        .current_width (current_width),
        .current_angle (current_angle),
        .at_target     (at_target)
    );

endmodule

// ===== rtl/spr_checker.sv =====
// Port-level checker for the servo pulse ramp controller, bound to the top level.
module spr_checker
    import spr_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cfg_we,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       out_channel,
    input logic [7:0]                 compare_high,
    input logic [1:0]                 compare_low,
    input logic [WIDTH_W-1:0]         current_width,
    input logic signed [ANGLE_W-1:0]  current_angle,
    input logic                       at_target
);

    logic [3:0] pend_reg;
    logic       cfg_dirty_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // track items taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            cfg_dirty_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer && !out_xfer)
            begin
                pend_reg <= pend_reg + 1'b1;
            end
            else if (out_xfer && !in_xfer)
            begin
                pend_reg <= pend_reg - 1'b1;
            end
            if (cfg_we)
            begin
                cfg_dirty_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({out_channel, compare_high,
            compare_low, current_width, current_angle, at_target}))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("result without a pending item");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (current_angle >= ANGLE_LO) && (current_angle <= ANGLE_HI))
        else $error("reported angle out of range");

    a_default_compare: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cfg_dirty_reg |-> {compare_high, compare_low} == current_width[15:6])
        else $error("compare word does not match width at default timing");

endmodule

bind servo_pulse_ramp_controller_top spr_checker u_spr_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the two-channel servo pulse ramp controller.
module tb_top;
    import spr_pkg::*;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam int GAP_PCT   = 14;
    localparam int MAX_SHOWN = 50;

    typedef struct {
        logic [2:0]                op;
        logic                      ch;
        logic [WIDTH_W-1:0]        wv;
        logic signed [ANGLE_W-1:0] ang;
    } servo_cmd_t;

    typedef struct {
        logic                      ch;
        logic [7:0]                hi;
        logic [1:0]                lo;
        logic [WIDTH_W-1:0]        width;
        logic signed [ANGLE_W-1:0] ang;
        logic                      hit;
    } servo_report_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [2:0]                opcode = '0;
    logic                      channel = 1'b0;
    logic [WIDTH_W-1:0]        width_value = '0;
    logic signed [ANGLE_W-1:0] angle = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      out_channel;
    logic [7:0]                compare_high;
    logic [1:0]                compare_low;
    logic [WIDTH_W-1:0]        current_width;
    logic signed [ANGLE_W-1:0] current_angle;
    logic                      at_target;

    servo_pulse_ramp_controller_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .channel       (channel),
        .width_value   (width_value),
        .angle         (angle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_channel   (out_channel),
        .compare_high  (compare_high),
        .compare_low   (compare_low),
        .current_width (current_width),
        .current_angle (current_angle),
        .at_target     (at_target)
    );

    // Predictor copy of the configuration and per-channel servo state
    logic [CPU_W-1:0]          cfg_cpu;
    logic [SHIFT_W-1:0]        cfg_shift;
    logic [WIDTH_W-1:0]        cfg_neg;
    logic [WIDTH_W-1:0]        cfg_pos;
    logic [WIDTH_W-1:0]        cfg_stride;
    logic [WIDTH_W-1:0]        width_now [2];
    logic [WIDTH_W-1:0]        width_goal [2];
    logic signed [ANGLE_W-1:0] angle_last [2];

    servo_cmd_t    servo_cmds[$];
    servo_report_t expected_reports[$];
    servo_cmd_t    next_cmd;
    servo_report_t want;
    logic          in_taken = 1'b0;
    logic          quiet_run = 1'b0;
    int            err_count = 0;
    int            phase_items;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [ANGLE_W-1:0] clamp_degrees(logic signed [ANGLE_W-1:0] a);
        if (a < ANGLE_LO)
            return ANGLE_LO;
        if (a > ANGLE_HI)
            return ANGLE_HI;
        return a;
    endfunction

    function automatic logic [WIDTH_W-1:0] degrees_to_width(logic signed [ANGLE_W-1:0] a);
        int span;
        int w;
        span = int'(cfg_pos) - int'(cfg_neg);
        // Signed division truncates toward zero, as the block does
        w = int'(cfg_neg) + (span * (int'(a) + int'(ANGLE_HI))) / ANGLE_SPAN;
        return 16'(w);
    endfunction

    function automatic logic [WIDTH_W-1:0] slew_step(logic [WIDTH_W-1:0] now,
                                                       logic [WIDTH_W-1:0] goal);
        logic [31:0] n;
        logic [31:0] g;
        logic [31:0] s;
        n = 32'(now);
        g = 32'(goal);
        s = 32'(cfg_stride);
        if (n < g) begin
            n = n + s;
            if (n > g)
                n = g;
        end
        else if (n > g) begin
            n = (n - g > s) ? n - s : g;
        end
        return 16'(n);
    endfunction

    // Apply one command to the predictor state and return the report it causes
    function automatic servo_report_t advance_servo(servo_cmd_t c);
        servo_report_t r;
        logic signed [ANGLE_W-1:0] a;
        logic [31:0] cmp;
        int ch;
        ch = int'(c.ch);
        a = clamp_degrees(c.ang);
        case (c.op)
            OP_SET_WIDTH:
            begin
                width_now[ch]  = c.wv;
                width_goal[ch] = c.wv;
            end
            OP_RAMP_WIDTH:
            begin
                width_goal[ch] = c.wv;
            end
            OP_SET_ANGLE:
            begin
                angle_last[ch] = a;
                width_now[ch]  = degrees_to_width(a);
                width_goal[ch] = width_now[ch];
            end
            OP_RAMP_ANGLE:
            begin
                angle_last[ch] = a;
                width_goal[ch] = degrees_to_width(a);
            end
            OP_TICK:
            begin
                width_now[ch] = slew_step(width_now[ch], width_goal[ch]);
            end
            default:
            begin
            end
        endcase
        cmp = (32'(width_now[ch]) * 32'(cfg_cpu)) >> (32'(FRAC_SHIFT) + 32'(cfg_shift));
        r.ch    = c.ch;
        r.hi    = cmp[9:2];
        r.lo    = cmp[1:0];
        r.width = width_now[ch];
        r.ang   = angle_last[ch];
        r.hit   = (width_now[ch] == width_goal[ch]);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        if (err_count < MAX_SHOWN)
            $display("tb_top: %0t mismatch in %s: got %0d, want %0d", $time, what, got, exp_val);
        err_count++;
    endtask

    // Driver: present commands at the falling edge, with random gaps and output stalls
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= quiet_run || ($urandom_range(99) >= GAP_PCT);
            if (!in_valid || in_taken) begin
                if (servo_cmds.size() > 0 && (quiet_run || $urandom_range(99) >= GAP_PCT)) begin
                    next_cmd = servo_cmds.pop_front();
                    in_valid    <= 1'b1;
                    opcode      <= next_cmd.op;
                    channel     <= next_cmd.ch;
                    width_value <= next_cmd.wv;
                    angle       <= next_cmd.ang;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each output transfer, then predict for each input transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken <= 1'b0;
        end
        else begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected result transfer", int'(current_width), 0);
                end
                else begin
                    want = expected_reports.pop_front();
                    if (out_channel !== want.ch)
                        report_mismatch("out_channel", int'(out_channel), int'(want.ch));
                    if (compare_high !== want.hi)
                        report_mismatch("compare_high", int'(compare_high), int'(want.hi));
                    if (compare_low !== want.lo)
                        report_mismatch("compare_low", int'(compare_low), int'(want.lo));
                    if (current_width !== want.width)
                        report_mismatch("current_width", int'(current_width), int'(want.width));
                    if (current_angle !== want.ang)
                        report_mismatch("current_angle", int'(current_angle), int'(want.ang));
                    if (at_target !== want.hit)
                        report_mismatch("at_target", int'(at_target), int'(want.hit));
                end
            end
            if (in_valid && in_ready)
                expected_reports.push_back(advance_servo('{opcode, channel, width_value, angle}));
        end
    end

    task automatic push_cmd(logic [2:0] op, logic ch, logic [WIDTH_W-1:0] wv,
                            logic signed [ANGLE_W-1:0] ang);
        servo_cmds.push_back('{op, ch, wv, ang});
        phase_items++;
    endtask

    function automatic logic [WIDTH_W-1:0] pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return 16'($urandom);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        // Mostly legal degrees; the rest covers the clamped codes
        if ($urandom_range(99) < 70)
            return 8'(int'($urandom_range(ANGLE_SPAN, 0)) + int'(ANGLE_LO));
        return 8'($urandom);
    endfunction

    task automatic push_random_cmd(logic ch);
        int r;
        r = $urandom_range(99);
        if (r < 15)
            push_cmd(OP_SET_WIDTH, ch, pick_width(), pick_angle());
        else if (r < 30)
            push_cmd(OP_RAMP_WIDTH, ch, pick_width(), pick_angle());
        else if (r < 40)
            push_cmd(OP_SET_ANGLE, ch, pick_width(), pick_angle());
        else if (r < 55)
            push_cmd(OP_RAMP_ANGLE, ch, pick_width(), pick_angle());
        else if (r < 95)
            push_cmd(OP_TICK, ch, pick_width(), pick_angle());
        else
            push_cmd(3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)), ch,
                     pick_width(), pick_angle());
    endtask

    // A ramp command followed by a run of ticks, now and then interleaved with the other channel
    task automatic push_ramp_run();
        logic ch;
        int ticks;
        ch = 1'($urandom);
        ticks = $urandom_range(10, 1);
        if ($urandom_range(1))
            push_cmd(OP_RAMP_WIDTH, ch, pick_width(), pick_angle());
        else
            push_cmd(OP_RAMP_ANGLE, ch, pick_width(), pick_angle());
        repeat (ticks) begin
            if ($urandom_range(99) < 20)
                push_random_cmd(~ch);
            push_cmd(OP_TICK, ch, pick_width(), pick_angle());
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CLOCKS_PER_US:  cfg_cpu    = val[CPU_W-1:0];
            REG_PRESCALE_SHIFT: cfg_shift  = val[SHIFT_W-1:0];
            REG_NEG_END_WIDTH:  cfg_neg    = val;
            REG_POS_END_WIDTH:  cfg_pos    = val;
            REG_RAMP_STRIDE:    cfg_stride = val;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_config(int cpu, int shift, int neg, int pos, int stride);
        write_reg(REG_CLOCKS_PER_US, 16'(cpu));
        write_reg(REG_PRESCALE_SHIFT, 16'(shift));
        write_reg(REG_NEG_END_WIDTH, 16'(neg));
        write_reg(REG_POS_END_WIDTH, 16'(pos));
        write_reg(REG_RAMP_STRIDE, 16'(stride));
    endtask

    // Hold until every queued command is sent and every report has come back
    task automatic wait_drained();
        while (servo_cmds.size() > 0 || in_valid || expected_reports.size() > 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    initial begin
        cfg_cpu    = RST_CLOCKS_PER_US;
        cfg_shift  = RST_PRESCALE_SHIFT;
        cfg_neg    = RST_NEG_END_WIDTH;
        cfg_pos    = RST_POS_END_WIDTH;
        cfg_stride = RST_RAMP_STRIDE;
        for (int i = 0; i < 2; i++) begin
            width_now[i]  = '0;
            width_goal[i] = '0;
            angle_last[i] = '0;
        end
        phase_items = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed commands under the reset configuration
        push_cmd(OP_SET_WIDTH, 1'b0, 16'd0, 8'sd0);
        push_cmd(OP_SET_WIDTH, 1'b1, 16'hFFFF, 8'sd0);
        push_cmd(OP_TICK, 1'b1, 16'd0, 8'sd0);
        push_cmd(OP_RAMP_WIDTH, 1'b1, 16'd0, 8'sd0);
        push_cmd(OP_TICK, 1'b1, 16'd0, 8'sd0);
        push_cmd(OP_SET_ANGLE, 1'b0, 16'd0, ANGLE_LO);
        push_cmd(OP_SET_ANGLE, 1'b0, 16'd0, ANGLE_HI);
        push_cmd(OP_SET_ANGLE, 1'b1, 16'hFFFF, -8'sd128);
        push_cmd(OP_SET_ANGLE, 1'b1, 16'hFFFF, 8'sd127);
        push_cmd(OP_SET_ANGLE, 1'b0, 16'd0, 8'sd0);
        // Ramp up and down by less than one stride: no overshoot
        push_cmd(OP_RAMP_WIDTH, 1'b0, 16'd23208, 8'sd0);
        push_cmd(OP_TICK, 1'b0, 16'd0, 8'sd0);
        push_cmd(OP_RAMP_WIDTH, 1'b0, 16'd23203, 8'sd0);
        push_cmd(OP_TICK, 1'b0, 16'd0, 8'sd0);
        push_cmd(OP_RAMP_ANGLE, 1'b1, 16'd0, 8'sd45);
        push_cmd(OP_TICK, 1'b1, 16'd0, 8'sd0);
        push_cmd(OP_TICK, 1'b0, 16'd0, 8'sd0);
        push_cmd(OP_UNUSED_FIRST, 1'b0, 16'd0, 8'sd0);
        push_cmd(OP_UNUSED_LAST, 1'b1, 16'hFFFF, -8'sd1);
        push_cmd(OP_RAMP_ANGLE, 1'b0, 16'h5555, -8'sd128);
        // Set cancels the ramp in progress
        push_cmd(OP_SET_WIDTH, 1'b0, 16'd100, 8'sd0);
        push_cmd(OP_TICK, 1'b0, 16'hAAAA, 8'sd0);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_config(1, 0, 0, 65535, 65535);
                1: load_config(64, 4, 65535, 0, 0);
                2: load_config(127, 7, 1000, 2000, 1);
                3: load_config(0, 5, 8000, 38400, 300);
                4: load_config(16, 2, 12000, 12000, 4096);
                default: load_config($urandom_range(64, 1), $urandom_range(4, 0),
                                     $urandom_range(65535), $urandom_range(65535),
                                     $urandom_range(2000, 1));
            endcase
            quiet_run = (phase == 4);
            phase_items = 0;
            while (phase_items < 225) begin
                if ($urandom_range(99) < 75)
                    push_ramp_run();
                else
                    push_random_cmd(1'($urandom));
            end
            wait_drained();
        end

        quiet_run = 1'b0;
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== servo_pulse_ramp_controller_top.f =====
rtl/spr_pkg.sv
rtl/spr_front.sv
rtl/spr_queue.sv
rtl/spr_back.sv
rtl/servo_pulse_ramp_controller_top.sv
rtl/spr_checker.sv
tb/tb_top.sv
